// ----- src/assert_macros.svh -----
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- src/gcd_pkg.sv -----
// Types, constants and helpers for the great-circle distance pipeline.
package gcd_pkg;

   localparam int CORDIC_STEPS = 30;
   localparam int ISQRT_STEPS  = 31;

   typedef logic signed [33:0] xy_type;
   typedef logic signed [34:0] z_type;
   typedef logic signed [35:0] ang_type;
   typedef logic signed [31:0] unit_type;

   localparam logic [32:0] RAD_PER_UDEG_Q58 = 33'd5030569068;
   localparam ang_type     PI_Q30           = 36'sd3373259426;
   localparam ang_type     HALF_PI_Q30      = 36'sd1686629713;
   localparam ang_type     TWO_PI_Q30       = 36'sd6746518852;
   localparam unit_type    ONE_Q30          = 32'sd1073741824;
   localparam xy_type      CORDIC_GAIN_Q30  = 34'sd652032874;
   localparam logic [22:0] EARTH_R_M        = 23'd6371000;
   localparam logic [24:0] MAX_DIST         = 25'd20015087;

   localparam z_type ATAN_Q30 [CORDIC_STEPS] = '{
      35'sd843314857, 35'sd497837829, 35'sd263043837, 35'sd133525159, 35'sd67021687,
      35'sd33543515,  35'sd16775851,  35'sd8388437,   35'sd4194283,   35'sd2097149,
      35'sd1048576,   35'sd524288,    35'sd262144,    35'sd131072,    35'sd65536,
      35'sd32768,     35'sd16384,     35'sd8192,      35'sd4096,      35'sd2048,
      35'sd1024,      35'sd512,       35'sd256,       35'sd128,       35'sd64,
      35'sd32,        35'sd16,        35'sd8,         35'sd4,         35'sd2
   };

   function automatic unit_type clamp_unit(input logic signed [63:0] v);
      unit_type r;
      if (v > 64'(ONE_Q30))
         r = ONE_Q30;
      else if (v < -64'(ONE_Q30))
         r = -ONE_Q30;
      else
         r = unit_type'(v);
      return r;
   endfunction

   function automatic ang_type wrap_pi(input ang_type a);
      ang_type r;
      if (a > PI_Q30)
         r = a - TWO_PI_Q30;
      else if (a < -PI_Q30)
         r = a + TWO_PI_Q30;
      else
         r = a;
      return r;
   endfunction

endpackage

// ----- src/gcd_cordic.sv -----
// Pipelined CORDIC, one iteration per stage, rotation or vectoring mode.
module gcd_cordic #(
   parameter bit VECTORING = 1'b0,
   parameter int TAG_W     = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  gcd_pkg::xy_type     in_x,
   input  gcd_pkg::xy_type     in_y,
   input  gcd_pkg::z_type      in_z,
   input  logic [TAG_W-1:0]    in_tag,
   output logic                out_valid,
   output gcd_pkg::xy_type     out_x,
   output gcd_pkg::xy_type     out_y,
   output gcd_pkg::z_type      out_z,
   output logic [TAG_W-1:0]    out_tag
);
   import gcd_pkg::*;

   logic             valid_ff [CORDIC_STEPS];
   xy_type           x_ff     [CORDIC_STEPS];
   xy_type           y_ff     [CORDIC_STEPS];
   z_type            z_ff     [CORDIC_STEPS];
   logic [TAG_W-1:0] tag_ff   [CORDIC_STEPS];

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
      logic             v_cur;
      xy_type           x_cur, y_cur, dx, dy, x_in, y_in;
      z_type            z_cur, z_in;
      logic [TAG_W-1:0] tag_cur;
      logic             rot_dir;

      if (i == 0) begin : g_first
         assign v_cur   = in_valid;
         assign x_cur   = in_x;
         assign y_cur   = in_y;
         assign z_cur   = in_z;
         assign tag_cur = in_tag;
      end else begin : g_next
         assign v_cur   = valid_ff[i-1];
         assign x_cur   = x_ff[i-1];
         assign y_cur   = y_ff[i-1];
         assign z_cur   = z_ff[i-1];
         assign tag_cur = tag_ff[i-1];
      end

      assign dx      = y_cur >>> i;
      assign dy      = x_cur >>> i;
      assign rot_dir = VECTORING ? !(y_cur > 0) : (z_cur >= 0);

      always_comb begin
         if (rot_dir) begin
            x_in = x_cur - dx;
            y_in = y_cur + dy;
            z_in = z_cur - ATAN_Q30[i];
         end else begin
            x_in = x_cur + dx;
            y_in = y_cur - dy;
            z_in = z_cur + ATAN_Q30[i];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (en) begin
            valid_ff[i] <= v_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i]   <= x_in;
            y_ff[i]   <= y_in;
            z_ff[i]   <= z_in;
            tag_ff[i] <= tag_cur;
         end
      end
   end

   assign out_valid = valid_ff[CORDIC_STEPS-1];
   assign out_x     = x_ff[CORDIC_STEPS-1];
   assign out_y     = y_ff[CORDIC_STEPS-1];
   assign out_z     = z_ff[CORDIC_STEPS-1];
   assign out_tag   = tag_ff[CORDIC_STEPS-1];

endmodule

// ----- src/gcd_isqrt.sv -----
// Pipelined integer square root, one result bit per stage.
module gcd_isqrt #(
   parameter int TAG_W = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [61:0]      in_n,
   input  logic [TAG_W-1:0] in_tag,
   output logic             out_valid,
   output logic [30:0]      out_root,
   output logic [TAG_W-1:0] out_tag
);
   import gcd_pkg::*;

   logic             valid_ff [ISQRT_STEPS];
   logic [61:0]      n_ff     [ISQRT_STEPS];
   logic [33:0]      rem_ff   [ISQRT_STEPS];
   logic [30:0]      root_ff  [ISQRT_STEPS];
   logic [TAG_W-1:0] tag_ff   [ISQRT_STEPS];

   for (genvar i = 0; i < ISQRT_STEPS; i++) begin : g_stage
      logic             v_cur;
      logic [61:0]      n_cur, n_in;
      logic [33:0]      rem_cur, rem_cat, trial, rem_in;
      logic [30:0]      root_cur, root_in;
      logic [TAG_W-1:0] tag_cur;

      if (i == 0) begin : g_first
         assign v_cur    = in_valid;
         assign n_cur    = in_n;
         assign rem_cur  = '0;
         assign root_cur = '0;
         assign tag_cur  = in_tag;
      end else begin : g_next
         assign v_cur    = valid_ff[i-1];
         assign n_cur    = n_ff[i-1];
         assign rem_cur  = rem_ff[i-1];
         assign root_cur = root_ff[i-1];
         assign tag_cur  = tag_ff[i-1];
      end

      assign rem_cat = {rem_cur[31:0], n_cur[61:60]};
      assign trial   = {1'b0, root_cur, 2'b01};
      assign n_in    = {n_cur[59:0], 2'b00};

      always_comb begin
         if (rem_cat >= trial) begin
            rem_in  = rem_cat - trial;
            root_in = {root_cur[29:0], 1'b1};
         end else begin
            rem_in  = rem_cat;
            root_in = {root_cur[29:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (en) begin
            valid_ff[i] <= v_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            n_ff[i]    <= n_in;
            rem_ff[i]  <= rem_in;
            root_ff[i] <= root_in;
            tag_ff[i]  <= tag_cur;
         end
      end
   end

   assign out_valid = valid_ff[ISQRT_STEPS-1];
   assign out_root  = root_ff[ISQRT_STEPS-1];
   assign out_tag   = tag_ff[ISQRT_STEPS-1];

endmodule

// ----- src/great_circle_distance_top.sv -----
// Throughput: one beat per cycle; the whole pipeline advances together and holds
// while a result sits unread in the output register.
// Depth is set by the two 30-stage CORDIC units and the 31-stage square root.
// Reset (synchronous, active high) clears every stage valid bit; no other state.
`include "assert_macros.svh"
module great_circle_distance_top #(
   parameter int ANGLE_FRAC_BITS = 29
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [27:0] req_lat_a,
   input  logic signed [28:0] req_lon_a,
   input  logic signed [27:0] req_lat_b,
   input  logic signed [28:0] req_lon_b,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [24:0]        rsp_distance_m
);
   import gcd_pkg::*;

   localparam int          SH1  = 58 - ANGLE_FRAC_BITS;
   localparam logic [63:0] RND1 = 64'd1 << (SH1 - 1);
   localparam int          SH2  = (ANGLE_FRAC_BITS > 30) ? ANGLE_FRAC_BITS - 30 : 1;
   localparam logic [63:0] RND2 = 64'd1 << (SH2 - 1);
   localparam int          LSH  = (ANGLE_FRAC_BITS < 30) ? 30 - ANGLE_FRAC_BITS : 0;

   logic pipe_en;
   logic rsp_valid_ff;

   assign pipe_en   = !rsp_valid_ff || rsp_ready;
   assign req_ready = pipe_en;

   // C1: magnitude times pi/180e6
   logic signed [28:0] coord [4];
   assign coord[0] = 29'(req_lat_a);
   assign coord[1] = 29'(req_lon_a);
   assign coord[2] = 29'(req_lat_b);
   assign coord[3] = 29'(req_lon_b);

   logic        c1_valid_ff;
   logic [61:0] prod_ff [4];
   logic        sgn_ff  [4];

   // C2: rounding to Q.30
   logic        c2_valid_ff;
   ang_type     ang_ff [4];

   for (genvar j = 0; j < 4; j++) begin : g_conv
      logic [28:0] mag;
      logic [61:0] prod_in;
      logic [63:0] r1, r2;
      ang_type     ang_in;

      assign mag     = coord[j][28] ? 29'(-coord[j]) : 29'(coord[j]);
      assign prod_in = 62'(mag) * 62'(RAD_PER_UDEG_Q58);
      assign r1      = (64'(prod_ff[j]) + RND1) >> SH1;
      if (ANGLE_FRAC_BITS > 30) begin : g_down
         assign r2 = (r1 + RND2) >> SH2;
      end else begin : g_up
         assign r2 = r1 << LSH;
      end
      assign ang_in = sgn_ff[j] ? -ang_type'(r2[35:0]) : ang_type'(r2[35:0]);

      always_ff @(posedge clock) begin
         if (pipe_en) begin
            prod_ff[j] <= prod_in;
            sgn_ff[j]  <= coord[j][28];
            ang_ff[j]  <= ang_in;
         end
      end
   end

   // C3: longitude difference; C4: wrap to [-pi, pi]; C5: fold to [-pi/2, pi/2]
   logic    c3_valid_ff, c4_valid_ff, c5_valid_ff;
   ang_type dif_ff  [3];
   ang_type wrap_ff [3];
   z_type   fold_ff [3];
   logic    neg_ff  [3];

   ang_type dif_in [3];
   assign dif_in[0] = ang_ff[0];
   assign dif_in[1] = ang_ff[2];
   assign dif_in[2] = ang_ff[1] - ang_ff[3];

   // cordic outputs, index 0 lat_a, 1 lat_b, 2 longitude difference
   logic   cor_valid;
   xy_type cor_x   [3];
   xy_type cor_y   [3];
   logic   cor_neg [3];

   for (genvar k = 0; k < 3; k++) begin : g_angle
      ang_type wrap_in;
      z_type   fold_in;
      logic    neg_in;

      assign wrap_in = wrap_pi(dif_ff[k]);

      always_comb begin
         if (wrap_ff[k] > HALF_PI_Q30) begin
            fold_in = z_type'(wrap_ff[k] - PI_Q30);
            neg_in  = 1'b1;
         end else if (wrap_ff[k] < -HALF_PI_Q30) begin
            fold_in = z_type'(wrap_ff[k] + PI_Q30);
            neg_in  = 1'b1;
         end else begin
            fold_in = z_type'(wrap_ff[k]);
            neg_in  = 1'b0;
         end
      end

      always_ff @(posedge clock) begin
         if (pipe_en) begin
            dif_ff[k]  <= dif_in[k];
            wrap_ff[k] <= wrap_in;
            fold_ff[k] <= fold_in;
            neg_ff[k]  <= neg_in;
         end
      end

      if (k == 0) begin : g_lead
         gcd_cordic #(.VECTORING(1'b0), .TAG_W(1)) u_rot (
            .clock     (clock),
            .reset     (reset),
            .en        (pipe_en),
            .in_valid  (c5_valid_ff),
            .in_x      (CORDIC_GAIN_Q30),
            .in_y      ('0),
            .in_z      (fold_ff[k]),
            .in_tag    (neg_ff[k]),
            .out_valid (cor_valid),
            .out_x     (cor_x[k]),
            .out_y     (cor_y[k]),
            .out_z     (),
            .out_tag   (cor_neg[k])
         );
      end else begin : g_side
         gcd_cordic #(.VECTORING(1'b0), .TAG_W(1)) u_rot (
            .clock     (clock),
            .reset     (reset),
            .en        (pipe_en),
            .in_valid  (c5_valid_ff),
            .in_x      (CORDIC_GAIN_Q30),
            .in_y      ('0),
            .in_z      (fold_ff[k]),
            .in_tag    (neg_ff[k]),
            .out_valid (),
            .out_x     (cor_x[k]),
            .out_y     (cor_y[k]),
            .out_z     (),
            .out_tag   (cor_neg[k])
         );
      end
   end

   // P0: restore quadrant and clamp
   logic     p0_valid_ff;
   unit_type sin_ff [3];
   unit_type cos_ff [3];

   for (genvar k = 0; k < 3; k++) begin : g_unit
      xy_type sx, cx;
      assign sx = cor_neg[k] ? -cor_y[k] : cor_y[k];
      assign cx = cor_neg[k] ? -cor_x[k] : cor_x[k];
      always_ff @(posedge clock) begin
         if (pipe_en) begin
            sin_ff[k] <= clamp_unit(64'(sx));
            cos_ff[k] <= clamp_unit(64'(cx));
         end
      end
   end

   // P1..P3: t = sa*sb + floor(ca*cb)*cd, rounded and clamped
   logic               p1_valid_ff, p2_valid_ff, t_valid_ff;
   logic signed [63:0] ss_ff, ss2_ff, cp_ff;
   logic signed [63:0] ss_in, ccw, cp_in, sum;
   unit_type           cc_ff, cd_ff, t_ff, cc_in, t_in;

   assign ss_in = 64'(sin_ff[0]) * 64'(sin_ff[1]);
   assign ccw   = (64'(cos_ff[0]) * 64'(cos_ff[1])) >>> 30;
   assign cc_in = unit_type'(ccw);
   assign cp_in = 64'(cc_ff) * 64'(cd_ff);
   assign sum   = (ss2_ff + cp_ff + 64'sd536870912) >>> 30;
   assign t_in  = clamp_unit(sum);

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         ss_ff  <= ss_in;
         cc_ff  <= cc_in;
         cd_ff  <= cos_ff[2];
         ss2_ff <= ss_ff;
         cp_ff  <= cp_in;
         t_ff   <= t_in;
      end
   end

   // P4: |t| squared; P5: 2^60 - t^2
   logic        sq_valid_ff, n_valid_ff;
   logic [30:0] at_in, at_ff, at2_ff;
   logic        tneg_ff, tneg2_ff;
   logic [61:0] sq_ff, n_ff, sq_in, n_in;

   assign at_in = t_ff[31] ? 31'(-t_ff) : 31'(t_ff);
   assign sq_in = 62'(at_in) * 62'(at_in);
   assign n_in  = (62'd1 << 60) - sq_ff;

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         at_ff    <= at_in;
         tneg_ff  <= t_ff[31];
         sq_ff    <= sq_in;
         at2_ff   <= at_ff;
         tneg2_ff <= tneg_ff;
         n_ff     <= n_in;
      end
   end

   logic        sq_out_valid;
   logic [30:0] root;
   logic [31:0] sq_tag;

   gcd_isqrt #(.TAG_W(32)) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (n_valid_ff),
      .in_n      (n_ff),
      .in_tag    ({tneg2_ff, at2_ff}),
      .out_valid (sq_out_valid),
      .out_root  (root),
      .out_tag   (sq_tag)
   );

   logic  ac_valid;
   z_type ac_z;
   logic  ac_neg;

   gcd_cordic #(.VECTORING(1'b1), .TAG_W(1)) u_acos (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (sq_out_valid),
      .in_x      ($signed({3'b000, sq_tag[30:0]})),
      .in_y      ($signed({3'b000, root})),
      .in_z      ('0),
      .in_tag    (sq_tag[31]),
      .out_valid (ac_valid),
      .out_x     (),
      .out_y     (),
      .out_z     (ac_z),
      .out_tag   (ac_neg)
   );

   // F0: central angle; F1: times radius; F2: meters, saturated
   logic        f0_valid_ff, f1_valid_ff;
   z_type       ang_full;
   logic [33:0] cang_ff;
   logic [56:0] dprod_ff, dprod_in;
   logic [26:0] dm;
   logic [24:0] dist_in, dist_ff;

   assign ang_full = ac_neg ? z_type'(PI_Q30) - ac_z : ac_z;
   assign dprod_in = 57'(cang_ff) * 57'(EARTH_R_M);
   assign dm       = dprod_ff[56:30];
   assign dist_in  = (dm > 27'(MAX_DIST)) ? MAX_DIST : dm[24:0];

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         cang_ff  <= ang_full[34] ? '0 : ang_full[33:0];
         dprod_ff <= dprod_in;
         dist_ff  <= dist_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_valid_ff  <= 1'b0;
         c2_valid_ff  <= 1'b0;
         c3_valid_ff  <= 1'b0;
         c4_valid_ff  <= 1'b0;
         c5_valid_ff  <= 1'b0;
         p0_valid_ff  <= 1'b0;
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         t_valid_ff   <= 1'b0;
         sq_valid_ff  <= 1'b0;
         n_valid_ff   <= 1'b0;
         f0_valid_ff  <= 1'b0;
         f1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         c1_valid_ff  <= req_valid;
         c2_valid_ff  <= c1_valid_ff;
         c3_valid_ff  <= c2_valid_ff;
         c4_valid_ff  <= c3_valid_ff;
         c5_valid_ff  <= c4_valid_ff;
         p0_valid_ff  <= cor_valid;
         p1_valid_ff  <= p0_valid_ff;
         p2_valid_ff  <= p1_valid_ff;
         t_valid_ff   <= p2_valid_ff;
         sq_valid_ff  <= t_valid_ff;
         n_valid_ff   <= sq_valid_ff;
         f0_valid_ff  <= ac_valid;
         f1_valid_ff  <= f0_valid_ff;
         rsp_valid_ff <= f1_valid_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_distance_m = dist_ff;

   `ASSERT_NEXT(a_stall_holds, clock, reset, !pipe_en, $stable(t_ff) && $stable(t_valid_ff))
   `ASSERT_IMPLY(a_t_unit, clock, reset, t_valid_ff, (t_ff <= ONE_Q30) && (t_ff >= -ONE_Q30))
   `ASSERT_IMPLY(a_dist_cap, clock, reset, rsp_valid_ff, rsp_distance_m <= MAX_DIST)

endmodule

// ----- tb/great_circle_distance_top_test.sv -----
// Self-checking testbench for the great-circle distance pipeline.
module great_circle_distance_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          FRAC_BITS  = 29;
   localparam longint      RAD_Q58    = 64'd5030569068;
   localparam longint      ONE        = 64'sd1073741824;
   localparam longint      PI         = 64'sd3373259426;
   localparam longint      HALF_PI    = 64'sd1686629713;
   localparam longint      TWO_PI     = 64'sd6746518852;
   localparam longint      GAIN       = 64'sd652032874;
   localparam longint      RADIUS     = 64'sd6371000;
   localparam longint      DIST_MAX   = 64'sd20015087;
   localparam int          RAND_ITEMS = 200;
   localparam int          IDLE_LIMIT = 5000;

   localparam longint ARCTAN [30] = '{
      843314857, 497837829, 263043837, 133525159, 67021687,
      33543515,  16775851,  8388437,   4194283,   2097149,
      1048576,   524288,    262144,    131072,    65536,
      32768,     16384,     8192,      4096,      2048,
      1024,      512,       256,       128,       64,
      32,        16,        8,         4,         2
   };

   typedef struct {
      logic signed [27:0] lat_a;
      logic signed [28:0] lon_a;
      logic signed [27:0] lat_b;
      logic signed [28:0] lon_b;
   } coord_pair_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic signed [27:0] req_lat_a;
   logic signed [28:0] req_lon_a;
   logic signed [27:0] req_lat_b;
   logic signed [28:0] req_lon_b;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [24:0]        rsp_distance_m;

   logic [24:0] expected_dist_q[$];
   int          errors;
   int          idle_cycles;
   int          sender_idle_pct;
   int          receiver_stall_pct;

   great_circle_distance_top #(.ANGLE_FRAC_BITS(FRAC_BITS)) DUT (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic longint udeg_to_rad(input longint udeg);
      logic [63:0] m;
      logic [63:0] r;
      m = udeg < 0 ? -udeg : udeg;
      r = (m * RAD_Q58 + (64'd1 << (57 - FRAC_BITS))) >> (58 - FRAC_BITS);
      if (FRAC_BITS >= 30)
         r = FRAC_BITS == 30 ? r : (r + (64'd1 << (FRAC_BITS - 31))) >> (FRAC_BITS - 30);
      else
         r = r << (30 - FRAC_BITS);
      return udeg < 0 ? -longint'(r) : longint'(r);
   endfunction

   function automatic longint clamp_one(input longint v);
      return v > ONE ? ONE : (v < -ONE ? -ONE : v);
   endfunction

   function automatic void sin_cos(input longint a, output longint s, output longint c);
      bit     flip;
      longint x, y, dx, dy;
      flip = 1'b0;
      x = GAIN;
      y = 0;
      while (a > PI) a -= TWO_PI;
      while (a < -PI) a += TWO_PI;
      if (a > HALF_PI) begin
         a -= PI;
         flip = 1'b1;
      end else if (a < -HALF_PI) begin
         a += PI;
         flip = 1'b1;
      end
      for (int i = 0; i < 30; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (a >= 0) begin
            x -= dx; y += dy; a -= ARCTAN[i];
         end else begin
            x += dx; y -= dy; a += ARCTAN[i];
         end
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      s = clamp_one(y);
      c = clamp_one(x);
   endfunction

   function automatic longint sqrt_floor(input logic [63:0] n);
      logic [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n -= res + b;
            res = (res >> 1) + b;
         end else
            res >>= 1;
         b >>= 2;
      end
      return longint'(res);
   endfunction

   function automatic longint arc_cos(input longint t);
      longint at, x, y, z, dx, dy;
      at = t < 0 ? -t : t;
      x = at;
      z = 0;
      y = sqrt_floor((64'd1 << 60) - at * at);
      for (int i = 0; i < 30; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y > 0) begin
            x += dx; y -= dy; z += ARCTAN[i];
         end else begin
            x -= dx; y += dy; z -= ARCTAN[i];
         end
      end
      return t < 0 ? PI - z : z;
   endfunction

   function automatic logic [24:0] distance_of(input coord_pair_type p);
      longint sa, ca, sb, cb, sd, cd, cc, t, ang, d;
      sin_cos(udeg_to_rad(p.lat_a), sa, ca);
      sin_cos(udeg_to_rad(p.lat_b), sb, cb);
      sin_cos(udeg_to_rad(p.lon_a) - udeg_to_rad(p.lon_b), sd, cd);
      cc = (ca * cb) >>> 30;
      t = clamp_one((sa * sb + cc * cd + (64'sd1 << 29)) >>> 30);
      ang = arc_cos(t);
      if (ang < 0) ang = 0;
      d = (ang * RADIUS) >>> 30;
      if (d > DIST_MAX) d = DIST_MAX;
      return d[24:0];
   endfunction

   always @(posedge clock) begin
      if (reset)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // scoreboard and watchdog
   always @(posedge clock) begin
      coord_pair_type p;
      logic [24:0] want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            p = '{req_lat_a, req_lon_a, req_lat_b, req_lon_b};
            expected_dist_q.push_back(distance_of(p));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_dist_q.size() == 0) begin
               $error("distance_m: unexpected beat, value %0d", rsp_distance_m);
               errors++;
            end else begin
               want = expected_dist_q.pop_front();
               if (rsp_distance_m !== want) begin
                  $error("distance_m: expected %0d, got %0d", want, rsp_distance_m);
                  errors++;
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
         else if (++idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   task automatic send_pair(input coord_pair_type p);
      int gap;
      gap = 0;
      while ($urandom_range(99) < sender_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_lat_a <= p.lat_a;
      req_lon_a <= p.lon_a;
      req_lat_b <= p.lat_b;
      req_lon_b <= p.lon_b;
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic coord_pair_type random_pair();
      coord_pair_type p;
      if ($urandom_range(99) < 15) begin
         p.lat_a = 28'($urandom);
         p.lon_a = 29'($urandom);
         p.lat_b = 28'($urandom);
         p.lon_b = 29'($urandom);
      end else begin
         p.lat_a = 28'(int'($urandom_range(180000000)) - 90000000);
         p.lon_a = 29'(int'($urandom_range(360000000)) - 180000000);
         if ($urandom_range(3) == 0) begin
            // nearby point
            p.lat_b = 28'(p.lat_a + int'($urandom_range(2000)) - 1000);
            p.lon_b = 29'(p.lon_a + int'($urandom_range(2000)) - 1000);
         end else begin
            p.lat_b = 28'(int'($urandom_range(180000000)) - 90000000);
            p.lon_b = 29'(int'($urandom_range(360000000)) - 180000000);
         end
      end
      return p;
   endfunction

   coord_pair_type directed [] = '{
      '{0, 0, 0, 0},
      '{90000000, 0, -90000000, 0},
      '{90000000, 0, 90000000, 123456789},
      '{0, 0, 0, 180000000},
      '{0, -180000000, 0, 180000000},
      '{0, 180000000, 0, -180000000},
      '{45000000, 90000000, -45000000, -90000000},
      '{-90000000, -180000000, 90000000, 180000000},
      '{28'sh7FFFFFF, 29'sh0FFFFFFF, -28'sh8000000, -29'sh10000000},
      '{-28'sh8000000, -29'sh10000000, 28'sh7FFFFFF, 29'sh0FFFFFFF},
      '{-28'sh8000000, 29'sh0FFFFFFF, -28'sh8000000, 29'sh0FFFFFFF},
      '{28'sh7FFFFFF, -29'sh10000000, 28'sh7FFFFFF, 29'sh0FFFFFFF},
      '{51500000, -120000, 51500001, -120000},
      '{51500000, -120000, 51500000, -119999},
      '{-33868800, 151209300, 40712800, -74006000},
      '{10, 10, -10, -10},
      '{0, 90000000, 0, -90000000},
      '{1, 0, -1, 179999999},
      '{89999999, 0, -89999999, 180000000}
   };

   initial begin
      errors = 0;
      idle_cycles = 0;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_lat_a <= '0;
      req_lon_a <= '0;
      req_lat_b <= '0;
      req_lon_b <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) send_pair(directed[i]);
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            1: begin
               sender_idle_pct = 68;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 68;
            end
            3: begin
               sender_idle_pct = 12;
               receiver_stall_pct = 12;
            end
            default: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 0;
            end
         endcase
         for (int n = 0; n < RAND_ITEMS; n++) begin
            if (ph == 1 && n == RAND_ITEMS / 2) begin
               req_valid <= 1'b0;
               while (expected_dist_q.size() != 0) @(posedge clock);
            end
            send_pair(random_pair());
         end
      end
      req_valid <= 1'b0;
      while (expected_dist_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+src
src/gcd_pkg.sv
src/gcd_cordic.sv
src/gcd_isqrt.sv
src/great_circle_distance_top.sv
tb/great_circle_distance_top_test.sv
